// ===== rtl/fifo_replacement_id_set_unit_defines.svh =====
// Assertion macros shared by the RTL files.
`ifndef FIFO_REPLACEMENT_ID_SET_UNIT_DEFINES_SVH
`define FIFO_REPLACEMENT_ID_SET_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Plain property, checked out of reset
`define FRIDS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Overlapping implication, checked out of reset
`define FRIDS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define FRIDS_ASSERT(lbl, prop, msg)
`define FRIDS_ASSERT_IMP(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/frids_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package frids_pkg;

  // Field widths
  localparam int ID_W  = 30;
  localparam int CAP_W = 5;
  localparam int OCC_W = 5;

  // Defaults
  localparam int               ENTRIES_DEF = 16;
  localparam logic [CAP_W-1:0] CAP_RESET   = 5'd16;

  // Command codes
  localparam logic CMD_ACCESS = 1'b0;
  localparam logic CMD_LIST   = 1'b1;

  // Sequencer state
  typedef enum logic {
    ST_IDLE,
    ST_LIST
  } state_e;

  // Per-cycle operation broadcast to every cell
  typedef struct packed {
    logic insert;  // shift toward older, cell 0 takes the new id
    logic rotate;  // shift toward newer, tail takes the head id
  } cell_op_t;

endpackage

`default_nettype wire

// ===== rtl/frids_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

// One slot of the age-ordered chain; cell 0 is the newest entry.
module frids_cell #(
  parameter int ENTRIES = frids_pkg::ENTRIES_DEF,
  parameter int IDX     = 0,
  localparam int CW     = $clog2(ENTRIES + 1)
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire frids_pkg::cell_op_t    op_i,
  input  wire logic [CW-1:0]          count_i,
  input  wire logic [frids_pkg::ID_W-1:0] key_i,
  input  wire logic [frids_pkg::ID_W-1:0] prev_id_i,
  input  wire logic [frids_pkg::ID_W-1:0] next_id_i,
  input  wire logic [frids_pkg::ID_W-1:0] head_id_i,
  output logic [frids_pkg::ID_W-1:0]  id_o,
  output logic [frids_pkg::ID_W-1:0]  tail_id_o,
  output logic                        hit_o
);
  import frids_pkg::*;

  localparam logic [CW-1:0] IDX_C = CW'(IDX);

  logic [ID_W-1:0] id_q, id_d;
  logic            held;
  logic            tail;

  // Position relative to the fill level
  assign held = IDX_C < count_i;
  assign tail = (IDX_C + CW'(1)) == count_i;

  // Next id: shift in from the newer neighbor, or rotate toward the head
  always_comb begin
    id_d = id_q;
    priority if (op_i.insert) begin
      id_d = prev_id_i;
    end else if (op_i.rotate) begin
      id_d = tail ? head_id_i : next_id_i;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q <= id_d;
  end

  assign id_o      = id_q;
  assign tail_id_o = tail ? id_q : '0;
  assign hit_o     = held && (id_q == key_i);

  `include "fifo_replacement_id_set_unit_defines.svh"

  // rst_ni is used by the assertion macros
  `FRIDS_ASSERT_IMP(a_tail_held, tail, held, "tail cell not held")
  `FRIDS_ASSERT_IMP(a_one_op, op_i.insert, !op_i.rotate, "insert and rotate together")
  `FRIDS_ASSERT_IMP(a_hit_held, hit_o, IDX_C < count_i, "hit on an empty cell")

endmodule

`default_nettype wire

// ===== rtl/fifo_replacement_id_set_unit.sv =====
// Access: one result beat, registered at the accepting edge;
//   one access per cycle while the result beats are taken.
// List: entry count N held, N beats (one if empty), one per cycle while the beats are
//   taken, once the list state is entered; the chain rotates once per beat, input stalled meanwhile.
// Reset: asynchronous, active low; store empty, capacity 16, no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module fifo_replacement_id_set_unit #(
  parameter int ENTRIES = frids_pkg::ENTRIES_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // configuration
  input  wire logic                        cfg_we_i,
  input  wire logic [frids_pkg::CAP_W-1:0] cfg_wdata_i,
  // input channel
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic                        command_i,
  input  wire logic [frids_pkg::ID_W-1:0]  ident_i,
  // output channel
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic                             hit_o,
  output logic                             evicted_valid_o,
  output logic [frids_pkg::ID_W-1:0]       evicted_id_o,
  output logic [frids_pkg::OCC_W-1:0]      occupancy_o,
  output logic                             list_valid_o,
  output logic [frids_pkg::ID_W-1:0]       list_id_o,
  output logic                             last_o
);
  import frids_pkg::*;

  localparam int CW = $clog2(ENTRIES + 1);

  // Clamp a raw capacity to 1..ENTRIES
  function automatic logic [CW-1:0] eff_cap(input logic [CAP_W-1:0] c);
    logic [CW-1:0] r;
    if (c == '0) begin
      r = CW'(1);
    end else if (32'(c) > ENTRIES) begin
      r = CW'(ENTRIES);
    end else begin
      r = CW'(c);
    end
    return r;
  endfunction

  state_e          state_q, state_d;
  logic [CAP_W-1:0] cap_q;
  logic [CW-1:0]   cap_eff;
  logic [CW-1:0]   cfg_cap;
  logic [CW-1:0]   count_q, count_d;
  logic [CW-1:0]   rem_q, rem_d;
  cell_op_t        op;

  logic [ID_W-1:0]    cell_id   [ENTRIES];
  logic [ID_W-1:0]    cell_tail [ENTRIES];
  logic [ENTRIES-1:0] cell_hit;
  logic               any_hit;
  logic [ID_W-1:0]    tail_id;

  logic               out_free;
  logic               acc;
  logic               out_load;
  logic               out_valid_q, out_valid_d;
  logic               hit_q, hit_d;
  logic               ev_valid_q, ev_valid_d;
  logic [ID_W-1:0]    ev_id_q, ev_id_d;
  logic [OCC_W-1:0]   occ_q, occ_d;
  logic               lv_q, lv_d;
  logic [ID_W-1:0]    lid_q, lid_d;
  logic               last_q, last_d;

  assign cap_eff = eff_cap(cap_q);
  assign cfg_cap = eff_cap(cfg_wdata_i);

  // Chain of cells, newest at index 0
  for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
    logic [ID_W-1:0] prev_id;
    logic [ID_W-1:0] next_id;
    if (k == 0) begin : g_head
      assign prev_id = ident_i;
    end else begin : g_mid
      assign prev_id = cell_id[k-1];
    end
    if (k == ENTRIES - 1) begin : g_end
      assign next_id = '0;
    end else begin : g_nxt
      assign next_id = cell_id[k+1];
    end
    frids_cell #(
      .ENTRIES (ENTRIES),
      .IDX     (k)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .op_i      (op),
      .count_i   (count_q),
      .key_i     (ident_i),
      .prev_id_i (prev_id),
      .next_id_i (next_id),
      .head_id_i (cell_id[0]),
      .id_o      (cell_id[k]),
      .tail_id_o (cell_tail[k]),
      .hit_o     (cell_hit[k])
    );
  end

  // Match and oldest-entry gather
  assign any_hit = |cell_hit;
  always_comb begin
    tail_id = '0;
    for (int k = 0; k < ENTRIES; k++) begin
      tail_id = tail_id | cell_tail[k];
    end
  end

  // Handshake
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == ST_IDLE) && out_free);
  assign acc        = in_valid_i && !in_stall_o;

  // Sequencer and result beat
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    rem_d      = rem_q;
    op         = '0;
    out_load   = 1'b0;
    hit_d      = 1'b0;
    ev_valid_d = 1'b0;
    ev_id_d    = '0;
    occ_d      = OCC_W'(count_q);
    lv_d       = 1'b0;
    lid_d      = '0;
    last_d     = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        if (acc) begin
          if (command_i == CMD_LIST) begin
            if (count_q == '0) begin
              out_load = 1'b1;
            end else begin
              rem_d   = count_q;
              state_d = ST_LIST;
            end
          end else begin
            out_load = 1'b1;
            if (any_hit) begin
              hit_d = 1'b1;
            end else begin
              op.insert = 1'b1;
              if (count_q >= cap_eff) begin
                ev_valid_d = 1'b1;
                ev_id_d    = tail_id;
              end else begin
                count_d = count_q + CW'(1);
              end
              occ_d = OCC_W'(count_d);
            end
          end
        end
      end
      ST_LIST: begin
        if (out_free) begin
          out_load  = 1'b1;
          op.rotate = 1'b1;
          lv_d      = 1'b1;
          lid_d     = cell_id[0];
          last_d    = (rem_q == CW'(1));
          rem_d     = rem_q - CW'(1);
          if (rem_q == CW'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    // Lowering capacity drops the oldest entries
    if (cfg_we_i && (count_q > cfg_cap)) begin
      count_d = cfg_cap;
    end
  end

  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cap_q       <= CAP_RESET;
      count_q     <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  // Result beat payload
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      hit_q      <= hit_d;
      ev_valid_q <= ev_valid_d;
      ev_id_q    <= ev_id_d;
      occ_q      <= occ_d;
      lv_q       <= lv_d;
      lid_q      <= lid_d;
      last_q     <= last_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign hit_o           = hit_q;
  assign evicted_valid_o = ev_valid_q;
  assign evicted_id_o    = ev_id_q;
  assign occupancy_o     = occ_q;
  assign list_valid_o    = lv_q;
  assign list_id_o       = lid_q;
  assign last_o          = last_q;

  `include "fifo_replacement_id_set_unit_defines.svh"

  `FRIDS_ASSERT(a_cnt_le_cap, count_q <= cap_eff, "occupancy above capacity")
  `FRIDS_ASSERT_IMP(a_list_rem, state_q == ST_LIST, rem_q != '0, "list with nothing left")
  `FRIDS_ASSERT_IMP(a_list_stall, state_q == ST_LIST, in_stall_o, "input taken during list")
  `FRIDS_ASSERT_IMP(a_mid_beat, out_load && !last_d, state_q == ST_LIST,
                    "non-final beat outside list")

endmodule

`default_nettype wire
